// ===== hw/rtl/ndt_pkg.sv =====
// Shared widths, register indexes and control types for the transpose address generator.
package ndt_pkg;

    localparam int DIMS_W     = 3;
    localparam int EXT_W      = 11;
    localparam int PERM_W     = 8;
    localparam int IDX_W      = 40;
    localparam int VAL_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int MUL_W      = IDX_W + EXT_W;

    localparam logic [PERM_W-1:0] PERM_RESET = 8'd228;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_DIMS = 3'd0,
        CFG_EXTENT_0 = 3'd1,
        CFG_EXTENT_1 = 3'd2,
        CFG_EXTENT_2 = 3'd3,
        CFG_EXTENT_3 = 3'd4,
        CFG_PERM     = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic busy;
        logic contrib_we;
    } seq_ctrl_t;

endpackage

// ===== hw/rtl/ndt_stride_seq.sv =====
// Configuration registers, permutation check and stride/contribution recompute sequencer.
module ndt_stride_seq #(
    parameter int MAX_DIMS   = 4,
    parameter int MAX_EXTENT = 1024,
    parameter int DIW        = 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ndt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ndt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [ndt_pkg::EXT_W-1:0]       cnt_sel,
    output ndt_pkg::seq_ctrl_t              ctrl,
    output logic [DIW-1:0]                  seq_idx,
    output logic [ndt_pkg::IDX_W-1:0]       product,
    output logic [ndt_pkg::IDX_W-1:0]       strides [MAX_DIMS],
    output logic [ndt_pkg::EXT_W-1:0]       ext_eff [MAX_DIMS],
    output logic [ndt_pkg::DIMS_W-1:0]      n_eff,
    output logic                            perm_bad
);

    typedef enum logic [3:0] {
        S_INIT    = 4'b0001,
        S_STRIDE  = 4'b0010,
        S_CONTRIB = 4'b0100,
        S_RUN     = 4'b1000
    } seq_state_t;

    seq_state_t                        state_reg, state_next;
    logic [DIW-1:0]                    idx_reg, idx_next;
    logic [ndt_pkg::IDX_W-1:0]         s_reg;
    logic [ndt_pkg::IDX_W-1:0]         stride_reg [MAX_DIMS];
    logic                              bad_reg;

    logic [ndt_pkg::DIMS_W-1:0]        num_dims_reg;
    logic [ndt_pkg::EXT_W-1:0]         ext_reg [MAX_DIMS];
    logic [ndt_pkg::PERM_W-1:0]        perm_reg;

    logic                              cfg_hit;
    logic                              bad_comb;
    logic [1:0]                        p_field;
    logic [ndt_pkg::IDX_W-1:0]         mul_a;
    logic [ndt_pkg::EXT_W-1:0]         mul_b;
    logic [ndt_pkg::MUL_W-1:0]         mul_full;
    logic [ndt_pkg::CFG_IDX_W-1:0]     ext_sel;

    // Configuration registers; extents beyond the synthesized dimension count are dropped.
    always_comb
    begin
        ext_sel = cfg_index - ndt_pkg::CFG_EXTENT_0;
        cfg_hit = 1'b0;
        if (cfg_we)
        begin
            unique case (cfg_index) inside
                ndt_pkg::CFG_NUM_DIMS,
                ndt_pkg::CFG_EXTENT_0, ndt_pkg::CFG_EXTENT_1,
                ndt_pkg::CFG_EXTENT_2, ndt_pkg::CFG_EXTENT_3,
                ndt_pkg::CFG_PERM:     cfg_hit = 1'b1;
                default:               cfg_hit = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_dims_reg <= ndt_pkg::DIMS_W'(1);
            perm_reg     <= ndt_pkg::PERM_RESET;
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                ext_reg[d] <= ndt_pkg::EXT_W'(1);
            end
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                ndt_pkg::CFG_NUM_DIMS:
                begin
                    num_dims_reg <= cfg_data[ndt_pkg::DIMS_W-1:0];
                end
                ndt_pkg::CFG_EXTENT_0, ndt_pkg::CFG_EXTENT_1,
                ndt_pkg::CFG_EXTENT_2, ndt_pkg::CFG_EXTENT_3:
                begin
                    if (int'(ext_sel) < MAX_DIMS)
                    begin
                        ext_reg[DIW'(ext_sel)] <= cfg_data[ndt_pkg::EXT_W-1:0];
                    end
                end
                ndt_pkg::CFG_PERM:
                begin
                    perm_reg <= cfg_data[ndt_pkg::PERM_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Clamped dimension count and extents.
    always_comb
    begin
        n_eff = num_dims_reg;
        if (num_dims_reg == '0)
        begin
            n_eff = ndt_pkg::DIMS_W'(1);
        end
        else if (int'(num_dims_reg) > MAX_DIMS)
        begin
            n_eff = ndt_pkg::DIMS_W'(MAX_DIMS);
        end
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            ext_eff[d] = ext_reg[d];
            if (ext_reg[d] == '0)
            begin
                ext_eff[d] = ndt_pkg::EXT_W'(1);
            end
            else if (int'(ext_reg[d]) > MAX_EXTENT)
            begin
                ext_eff[d] = ndt_pkg::EXT_W'(MAX_EXTENT);
            end
        end
    end

    // The order is a permutation when each field in use names a distinct dimension below n.
    always_comb
    begin
        logic [3:0] seen;
        logic [1:0] p;
        seen     = '0;
        bad_comb = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            p = perm_reg[2*k +: 2];
            if (k < int'(n_eff))
            begin
                if ((ndt_pkg::DIMS_W'(p) >= n_eff) || seen[p])
                begin
                    bad_comb = 1'b1;
                end
                seen[p] = 1'b1;
            end
        end
    end

    // One shared multiplier: running stride times extent, or stride times counter.
    always_comb
    begin
        p_field = perm_reg[2*idx_reg +: 2];
        if (state_reg == S_STRIDE)
        begin
            mul_a = s_reg;
            mul_b = ext_eff[DIW'(p_field)];
        end
        else
        begin
            mul_a = stride_reg[idx_reg];
            mul_b = cnt_sel;
        end
        mul_full = mul_a * mul_b;
        product  = mul_full[ndt_pkg::IDX_W-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            S_INIT:
            begin
                if (bad_comb)
                begin
                    state_next = S_CONTRIB;
                    idx_next   = '0;
                end
                else
                begin
                    state_next = S_STRIDE;
                    idx_next   = DIW'(n_eff - ndt_pkg::DIMS_W'(1));
                end
            end
            S_STRIDE:
            begin
                if (idx_reg == '0)
                begin
                    state_next = S_CONTRIB;
                end
                else
                begin
                    idx_next = idx_reg - DIW'(1);
                end
            end
            S_CONTRIB:
            begin
                if (int'(idx_reg) == MAX_DIMS - 1)
                begin
                    state_next = S_RUN;
                    idx_next   = '0;
                end
                else
                begin
                    idx_next = idx_reg + DIW'(1);
                end
            end
            S_RUN:
            begin
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
        if (cfg_hit)
        begin
            state_next = S_INIT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            idx_reg   <= '0;
            bad_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (state_reg == S_INIT)
            begin
                bad_reg <= bad_comb;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
        begin
            s_reg <= ndt_pkg::IDX_W'(1);
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                stride_reg[d] <= '0;
            end
        end
        else if (state_reg == S_STRIDE)
        begin
            stride_reg[DIW'(p_field)] <= s_reg;
            s_reg                     <= product;
        end
    end

    assign ctrl.busy       = (state_reg != S_RUN);
    assign ctrl.contrib_we = (state_reg == S_CONTRIB);
    assign seq_idx         = idx_reg;
    assign strides         = stride_reg;
    assign perm_bad        = bad_reg;

endmodule

// ===== hw/rtl/nd_tensor_transpose_address.sv =====
// Top level of the N-dimensional tensor transpose address generator.
//
//  channel   | handshake            | payload
//  ----------+----------------------+----------------------------------------------
//  input     | in_valid / in_stall  | elem_value[31:0], first
//  output    | out_valid / out_stall| dst_index[39:0], out_value[31:0], last,
//            |                      | perm_error
//  config    | cfg_we               | cfg_index[2:0], cfg_data[10:0]
//
// One item is accepted per cycle while in_stall is low, and its result appears in the
// output register on the following cycle.
// After reset and after every configuration write the strides and the per-dimension
// address contributions are rebuilt by one shared multiplier in S_INIT, S_STRIDE (skipped
// when the order is not a permutation) and S_CONTRIB, with in_stall high meanwhile.
// in_stall is also high while a result waits in the output register under out_stall.
module nd_tensor_transpose_address #(
    parameter int MAX_DIMS   = 4,
    parameter int MAX_EXTENT = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [ndt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ndt_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [ndt_pkg::VAL_W-1:0]       elem_value,
    input  logic                            first,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [ndt_pkg::IDX_W-1:0]       dst_index,
    output logic [ndt_pkg::VAL_W-1:0]       out_value,
    output logic                            last,
    output logic                            perm_error
);

    // Counter width covers every value below the largest usable extent.
    localparam int CW  = ($clog2(MAX_EXTENT) < ndt_pkg::EXT_W) ?
                         $clog2(MAX_EXTENT) : ndt_pkg::EXT_W;
    localparam int DIW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    ndt_pkg::seq_ctrl_t                ctrl;
    logic [DIW-1:0]                    seq_idx;
    logic [ndt_pkg::IDX_W-1:0]         product;
    logic [ndt_pkg::IDX_W-1:0]         strides [MAX_DIMS];
    logic [ndt_pkg::EXT_W-1:0]         ext_eff [MAX_DIMS];
    logic [ndt_pkg::DIMS_W-1:0]        n_eff;
    logic                              perm_bad;

    // Source coordinates and, per dimension, coordinate times destination stride.
    logic [CW-1:0]                     cnt_reg     [MAX_DIMS];
    logic [CW-1:0]                     cnt_next    [MAX_DIMS];
    logic [ndt_pkg::IDX_W-1:0]         contrib_reg [MAX_DIMS];
    logic [ndt_pkg::IDX_W-1:0]         contrib_next[MAX_DIMS];

    logic                              out_valid_reg;
    logic [ndt_pkg::IDX_W-1:0]         dst_index_reg, dst_index_next;
    logic [ndt_pkg::VAL_W-1:0]         out_value_reg;
    logic                              last_reg, last_next;
    logic                              perm_error_reg;

    logic                              accept;
    logic                              cnt_zero;

    ndt_stride_seq #(
        .MAX_DIMS   (MAX_DIMS),
        .MAX_EXTENT (MAX_EXTENT),
        .DIW        (DIW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cnt_sel   (ndt_pkg::EXT_W'(cnt_reg[seq_idx])),
        .ctrl      (ctrl),
        .seq_idx   (seq_idx),
        .product   (product),
        .strides   (strides),
        .ext_eff   (ext_eff),
        .n_eff     (n_eff),
        .perm_bad  (perm_bad)
    );

    // The output register frees up in the same cycle its result is taken.
    assign in_stall = ctrl.busy || (out_valid_reg && out_stall);
    assign accept   = in_valid && !in_stall;

    // A first item sees all-zero coordinates. The destination index is the sum of the
    // active contributions; the mixed-radix step then moves each contribution that the carry
    // reaches by its stride or clears it on wrap, so no multiply sits on the item path.
    always_comb
    begin
        logic [CW-1:0]             cnt_e     [MAX_DIMS];
        logic [ndt_pkg::IDX_W-1:0] contrib_e [MAX_DIMS];
        logic                      wrap      [MAX_DIMS];
        logic                      carry     [MAX_DIMS];
        logic                      carry_up;
        dst_index_next = '0;
        last_next      = 1'b1;
        carry_up       = 1'b0;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            cnt_e[d]     = first ? '0 : cnt_reg[d];
            contrib_e[d] = first ? '0 : contrib_reg[d];
            wrap[d]      = (ndt_pkg::EXT_W'(cnt_e[d]) >= (ext_eff[d] - ndt_pkg::EXT_W'(1)));
            if (d < int'(n_eff))
            begin
                dst_index_next = dst_index_next + contrib_e[d];
                if (!wrap[d])
                begin
                    last_next = 1'b0;
                end
            end
        end
        for (int d = MAX_DIMS - 1; d >= 0; d--)
        begin
            if (d == int'(n_eff) - 1)
            begin
                carry[d] = 1'b1;
            end
            else if (d < int'(n_eff) - 1)
            begin
                carry[d] = carry_up;
            end
            else
            begin
                carry[d] = 1'b0;
            end
            carry_up = carry[d] && wrap[d];
        end
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            cnt_next[d]     = cnt_e[d];
            contrib_next[d] = contrib_e[d];
            if (carry[d])
            begin
                if (wrap[d])
                begin
                    cnt_next[d]     = '0;
                    contrib_next[d] = '0;
                end
                else
                begin
                    cnt_next[d]     = cnt_e[d] + CW'(1);
                    contrib_next[d] = contrib_e[d] + strides[d];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_DIMS; d++)
            begin
                cnt_reg[d]     <= '0;
                contrib_reg[d] <= '0;
            end
        end
        else if (accept)
        begin
            cnt_reg     <= cnt_next;
            contrib_reg <= contrib_next;
        end
        else if (ctrl.contrib_we)
        begin
            contrib_reg[seq_idx] <= product;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= accept || (out_valid_reg && out_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            dst_index_reg  <= perm_bad ? '0 : dst_index_next;
            out_value_reg  <= elem_value;
            last_reg       <= last_next;
            perm_error_reg <= perm_bad;
        end
    end

    assign out_valid  = out_valid_reg;
    assign dst_index  = dst_index_reg;
    assign out_value  = out_value_reg;
    assign last       = last_reg;
    assign perm_error = perm_error_reg;

    // High when every coordinate in use is zero; a wrap clears only those, a first item clears all.
    always_comb
    begin
        cnt_zero = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++)
        begin
            if ((d < int'(n_eff)) && (cnt_reg[d] != '0))
            begin
                cnt_zero = 1'b0;
            end
        end
    end

    // A flagged permutation error always comes with a zero destination index.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && perm_error |-> dst_index == '0)
        else $error("perm_error result with nonzero dst_index");

    // An item that restarts the counters maps to destination index zero.
    a_first_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && first |=> out_valid && dst_index == '0)
        else $error("first item did not map to index zero");

    // After the final element of a tensor every coordinate in use is back at zero.
    a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_next |=> cnt_zero)
        else $error("counters not cleared after last element");

    // The contribution rebuild never overlaps an accepted item.
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.contrib_we |-> !accept)
        else $error("item accepted during contribution rebuild");

endmodule
